// ===== rtl/fsw_pkg.sv =====
// Shared constants, codes and types of the stop-and-wait frame transmitter.
package fsw_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
	localparam logic [7:0]  ACK_CODE     = 8'd6;

	localparam logic [7:0]  RST_NODE_ID     = 8'd49;
	localparam logic [7:0]  RST_MAX_RETRIES = 8'd15;
	localparam logic [15:0] RST_ACK_TIMEOUT = 16'd15;
	localparam logic [7:0]  RST_FIRST_SEQ   = 8'd48;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_RESP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_FRAME  = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_FAIL   = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_NODE_ID     = 2'd0,
		REG_MAX_RETRIES = 2'd1,
		REG_ACK_TIMEOUT = 2'd2,
		REG_FIRST_SEQ   = 2'd3
	} reg_idx_t;

	// One job for the transmit side: a whole frame or a single status result.
	typedef struct packed {
		logic             is_frame;
		kind_t            kind;
		logic [7:0]       id;
		logic [7:0]       seq;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic back_busy;
	} front_stat_t;

endpackage

// ===== rtl/fsw_in_if.sv =====
// Input channel: operation and its operands with a valid/ready handshake.
interface fsw_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic [7:0] resp_id;
	logic [7:0] resp_code;

	modport source (output valid, output operation, output data_byte, output resp_id,
		output resp_code, input ready);
	modport sink (input valid, input operation, input data_byte, input resp_id,
		input resp_code, output ready);
endinterface

// ===== rtl/fsw_out_if.sv =====
// Result channel: frame bytes and status results with a valid/ready handshake.
interface fsw_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic       last_of_frame;

	modport source (output valid, output kind, output tx_byte, output last_of_frame,
		input ready);
	modport sink (input valid, input kind, input tx_byte, input last_of_frame,
		output ready);
endinterface

// ===== rtl/fsw_front.sv =====
// Front end: registers, input decode, framing and the stop-and-wait protocol state.
module fsw_front import fsw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fsw_in_if.sink        item,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  front_stat_t   stat,
	output logic          push,
	output cmd_t          push_data,
	output mem_wr_t       wr
);

	typedef enum logic [1:0] {
		PH_COLLECT = 2'd0,
		PH_AWAIT   = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	phase_t           phase_q;
	logic [LEN_W-1:0] fill_q;
	logic [7:0]       seqn_q;
	logic [7:0]       attempt_q;
	logic [15:0]      wait_q;
	logic             ends_q;
	logic [7:0]       id_q;
	logic [7:0]       seqb_q;

	logic [7:0]  node_id_q;
	logic [7:0]  max_retries_q;
	logic [15:0] timeout_q;
	logic [7:0]  first_seq_q;

	op_t              op;
	logic             accept;
	logic             hold;
	logic             is_nl;
	logic [LEN_W-1:0] wr_pos;
	logic [LEN_W-1:0] next_fill;
	logic             closes;
	logic [16:0]      next_wait;
	logic             timed_out;
	logic             is_ack;
	logic [7:0]       seq_byte;

	assign op        = op_t'(item.operation);
	assign is_nl     = (item.data_byte == NEWLINE_BYTE);
	assign wr_pos    = (fill_q < LEN_W'(2) || fill_q >= LEN_W'(FRAME_BYTES)) ?
		LEN_W'(2) : fill_q;
	assign next_fill = wr_pos + LEN_W'(1);
	assign closes    = (next_fill == LEN_W'(FRAME_BYTES)) || is_nl;
	assign next_wait = {1'b0, wait_q} + 17'd1;
	assign timed_out = (next_wait > {1'b0, timeout_q});
	assign is_ack    = (item.resp_id == id_q) && (item.resp_code == ACK_CODE);
	assign seq_byte  = first_seq_q + seqn_q;

	// A new payload byte would overwrite the frame store, so it waits until
	// every queued or running transmission has finished reading it.
	assign hold = (op == OP_BYTE) && (phase_q != PH_AWAIT) && (phase_q != PH_DISCARD) &&
		(!stat.q_empty || stat.back_busy);
	assign item.ready = !stat.q_full && !hold;
	assign accept     = item.valid && item.ready;

	always_comb begin
		push      = 1'b0;
		push_data = '{is_frame: 1'b0, kind: KIND_ACK, id: id_q, seq: seqb_q, len: fill_q};
		wr        = '{en: 1'b0, addr: wr_pos[IDX_W-1:0], data: item.data_byte};
		if (accept) begin
			case (op)
				OP_BYTE: begin
					case (phase_q)
						PH_AWAIT: begin
							push           = 1'b1;
							push_data.kind = KIND_REJECT;
						end
						PH_DISCARD: begin
						end
						default: begin
							wr.en = 1'b1;
							if (closes) begin
								push               = 1'b1;
								push_data.is_frame = 1'b1;
								push_data.kind     = KIND_FRAME;
								push_data.id       = node_id_q;
								push_data.seq      = seq_byte;
								push_data.len      = next_fill;
							end
						end
					endcase
				end
				OP_TICK: begin
					if (phase_q == PH_AWAIT && timed_out) begin
						push = 1'b1;
						if (attempt_q < max_retries_q) begin
							push_data.is_frame = 1'b1;
							push_data.kind     = KIND_FRAME;
						end else begin
							push_data.kind = KIND_FAIL;
						end
					end
				end
				OP_RESP: begin
					if (phase_q == PH_AWAIT && is_ack) begin
						push           = 1'b1;
						push_data.kind = KIND_ACK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q     <= RST_NODE_ID;
			max_retries_q <= RST_MAX_RETRIES;
			timeout_q     <= RST_ACK_TIMEOUT;
			first_seq_q   <= RST_FIRST_SEQ;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_NODE_ID:     node_id_q     <= cfg_data[7:0];
				REG_MAX_RETRIES: max_retries_q <= cfg_data[7:0];
				REG_ACK_TIMEOUT: timeout_q     <= cfg_data;
				REG_FIRST_SEQ:   first_seq_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COLLECT;
			fill_q    <= LEN_W'(2);
			seqn_q    <= 8'd0;
			attempt_q <= 8'd0;
			wait_q    <= 16'd0;
			ends_q    <= 1'b0;
			id_q      <= 8'd0;
			seqb_q    <= 8'd0;
		end else if (accept) begin
			case (op)
				OP_BYTE: begin
					case (phase_q)
						PH_AWAIT: begin
						end
						PH_DISCARD: begin
							if (is_nl) begin
								phase_q <= PH_COLLECT;
							end
						end
						default: begin
							fill_q <= next_fill;
							if (closes) begin
								id_q      <= node_id_q;
								seqb_q    <= seq_byte;
								ends_q    <= is_nl;
								phase_q   <= PH_AWAIT;
								attempt_q <= 8'd0;
								wait_q    <= 16'd0;
							end
						end
					endcase
				end
				OP_TICK: begin
					if (phase_q == PH_AWAIT) begin
						if (!timed_out) begin
							wait_q <= next_wait[15:0];
						end else begin
							wait_q <= 16'd0;
							if (attempt_q < max_retries_q) begin
								attempt_q <= attempt_q + 8'd1;
							end else begin
								fill_q    <= LEN_W'(2);
								seqn_q    <= 8'd0;
								attempt_q <= 8'd0;
								phase_q   <= ends_q ? PH_COLLECT : PH_DISCARD;
							end
						end
					end
				end
				OP_RESP: begin
					if (phase_q == PH_AWAIT && is_ack) begin
						seqn_q    <= ends_q ? 8'd0 : seqn_q + 8'd1;
						fill_q    <= LEN_W'(2);
						attempt_q <= 8'd0;
						wait_q    <= 16'd0;
						phase_q   <= PH_COLLECT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_wr_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (stat.q_empty && !stat.back_busy))
		else $error("frame store written while a transmission may still read it");

	a_await_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AWAIT |-> (fill_q > LEN_W'(2) && fill_q <= LEN_W'(FRAME_BYTES)))
		else $error("frame length out of range while awaiting acknowledgement");

endmodule

// ===== rtl/fsw_cmd_fifo.sv =====
// Short job queue between the protocol front end and the transmit side.
module fsw_cmd_fifo import fsw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == Q_CW'(Q_DEPTH));
	assign empty   = (count_q == Q_CW'(0));
	assign head    = slot_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_q + Q_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + Q_CW'(1);
				2'b01:   count_q <= count_q - Q_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

endmodule

// ===== rtl/fsw_back.sv =====
// Transmit side: frame store and the output register that walks jobs into results.
module fsw_back import fsw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_wr_t    wr,
	input  cmd_t       head,
	input  logic       q_empty,
	output logic       pop,
	output logic       busy,
	fsw_out_if.source  result
);

	typedef enum logic {
		S_IDLE = 1'b0,
		S_PUT  = 1'b1
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [LEN_W-1:0] idx_q;
	logic [7:0]       rdata_q;
	logic [7:0]       store [FRAME_BYTES];

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             out_free;
	logic             load_out;
	logic             is_last;
	logic [LEN_W-1:0] idx_next;
	logic             rd_en;
	logic [7:0]       frame_byte;

	assign out_free   = !out_valid_q || result.ready;
	assign load_out   = (state_q == S_PUT) && out_free;
	assign idx_next   = idx_q + LEN_W'(1);
	assign is_last    = (idx_next == cmd_q.len);
	assign pop        = (state_q == S_IDLE) && !q_empty;
	assign busy       = (state_q != S_IDLE);
	// The byte after the one being loaded is fetched in the same cycle.
	assign rd_en      = (state_q == S_PUT) && out_free && cmd_q.is_frame && !is_last;
	assign frame_byte = (idx_q == LEN_W'(0)) ? cmd_q.id :
		(idx_q == LEN_W'(1)) ? cmd_q.seq : rdata_q;

	assign result.valid         = out_valid_q;
	assign result.kind          = out_kind_q;
	assign result.tx_byte       = out_byte_q;
	assign result.last_of_frame = out_last_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= store[idx_next[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !result.ready);
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						idx_q   <= '0;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (cmd_q.is_frame) begin
							idx_q <= idx_next;
							if (is_last) begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (load_out) begin
			if (cmd_q.is_frame) begin
				out_kind_q <= KIND_FRAME;
				out_byte_q <= frame_byte;
				out_last_q <= is_last;
			end else begin
				out_kind_q <= cmd_q.kind;
				out_byte_q <= 8'd0;
				out_last_q <= 1'b0;
			end
		end
	end

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT && cmd_q.is_frame) |-> (idx_q < cmd_q.len))
		else $error("frame walk ran past the frame length");

	a_last_is_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_kind_q == KIND_FRAME))
		else $error("end-of-frame mark on a status result");

endmodule

// ===== rtl/frame_segmenter_stop_and_wait_tx_core.sv =====
// Stop-and-wait frame transmitter: front end, job queue and transmit side.
// Path: the first result of an input transfer passes the job queue, the job register and
// the output register, for a frame byte as for a status result (acknowledged, failed, rejected).
// Throughput: one input item per cycle while the job queue has room; a job is fetched in
// the idle state and its results are then loaded while the output register is free. A payload
// byte waits while any job is queued or being sent, since it reuses the frame store.
// Reset (arst_n low) clears all control state and loads the register reset values.
module frame_segmenter_stop_and_wait_tx_core import fsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fsw_in_if.sink      item,
	fsw_out_if.source   result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	front_stat_t stat;
	logic        push;
	cmd_t        push_data;
	mem_wr_t     wr;
	logic        pop;
	cmd_t        head;
	logic        q_full;
	logic        q_empty;
	logic        back_busy;

	assign stat = '{q_full: q_full, q_empty: q_empty, back_busy: back_busy};

	fsw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.push      (push),
		.push_data (push_data),
		.wr        (wr)
	);

	fsw_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	fsw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.busy    (back_busy),
		.result  (result)
	);

endmodule
